// ----- rtl/core/oaep_sha1_unpad_unit_assert.svh -----
// assertion macros for the oaep sha-1 unpad unit
`ifndef OAEP_SHA1_UNPAD_UNIT_ASSERT_SVH
`define OAEP_SHA1_UNPAD_UNIT_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define OSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define OSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/osu_pkg.sv -----
// shared types, codes and constants of the oaep sha-1 unpad unit
package osu_pkg;

  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_MESSAGE = 1'b1;

  localparam logic [8:0] MODULUS_RESET = 9'd128;
  localparam logic [6:0] MESSAGE_RESET = 7'd64;
  localparam int ENC_MIN_BYTES = 42;
  localparam int HDR_BYTES     = 21;
  localparam int SEED_BYTES    = 20;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_HINIT,
    OP_HFETCH,
    OP_HBYTE,
    OP_ROUND,
    OP_HADD,
    OP_SFETCH,
    OP_SXOR,
    OP_DFETCH,
    OP_DWRITE,
    OP_FIN,
    OP_OFETCH,
    OP_OLOAD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic seed_src;
  } osu_cmd_t;

  typedef struct packed {
    logic run_start;
    logic blk_full;
    logic round_last;
    logic more_blks;
    logic j_last;
    logic db_last;
    logic out_last;
  } osu_sts_t;

  // sha-1 of the empty label
  function automatic logic [7:0] lhash_byte(input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'hda;
      5'd1:    b = 8'h39;
      5'd2:    b = 8'ha3;
      5'd3:    b = 8'hee;
      5'd4:    b = 8'h5e;
      5'd5:    b = 8'h6b;
      5'd6:    b = 8'h4b;
      5'd7:    b = 8'h0d;
      5'd8:    b = 8'h32;
      5'd9:    b = 8'h55;
      5'd10:   b = 8'hbf;
      5'd11:   b = 8'hef;
      5'd12:   b = 8'h95;
      5'd13:   b = 8'h60;
      5'd14:   b = 8'h18;
      5'd15:   b = 8'h90;
      5'd16:   b = 8'haf;
      5'd17:   b = 8'hd8;
      5'd18:   b = 8'h07;
      5'd19:   b = 8'h09;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/osu_in_if.sv -----
// input channel: one encoded byte per word
interface osu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] enc_byte;
  modport source (output valid, output enc_byte, input ready);
  modport sink (input valid, input enc_byte, output ready);
endinterface

// ----- rtl/core/osu_out_if.sv -----
// result channel: one message byte per word with error and last flags
interface osu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       decode_error;
  logic       last_byte;
  modport source (output valid, output msg_byte, output decode_error, output last_byte,
                  input ready);
  modport sink (input valid, input msg_byte, input decode_error, input last_byte,
                output ready);
endinterface

// ----- rtl/core/osu_ram.sv -----
// generic single write, single registered read ram
module osu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/osu_ctrl.sv -----
// controller state machine of the oaep sha-1 unpad unit
module osu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  osu_pkg::osu_sts_t  sts,
  input  logic               out_ready,
  output osu_pkg::osu_cmd_t  cmd,
  output logic               in_ready,
  output logic               out_valid
);
  typedef enum logic [13:0] {
    ST_LOAD   = 14'b00000000000001,
    ST_HINIT  = 14'b00000000000010,
    ST_HFETCH = 14'b00000000000100,
    ST_HBYTE  = 14'b00000000001000,
    ST_ROUND  = 14'b00000000010000,
    ST_HADD   = 14'b00000000100000,
    ST_SFETCH = 14'b00000001000000,
    ST_SXOR   = 14'b00000010000000,
    ST_DFETCH = 14'b00000100000000,
    ST_DWRITE = 14'b00001000000000,
    ST_FIN    = 14'b00010000000000,
    ST_OFETCH = 14'b00100000000000,
    ST_OLOAD  = 14'b01000000000000,
    ST_OHOLD  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   job_r, job_nxt;   // 0: hash over masked db, 1: hash over seed

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      job_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    cmd.op       = osu_pkg::OP_IDLE;
    cmd.seed_src = job_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      ST_LOAD: begin
        cmd.op   = osu_pkg::OP_LOAD;
        in_ready = 1'b1;
        if (sts.run_start) begin
          state_nxt = ST_HINIT;
          job_nxt   = 1'b0;
        end
      end
      ST_HINIT: begin
        cmd.op    = osu_pkg::OP_HINIT;
        state_nxt = ST_HFETCH;
      end
      ST_HFETCH: begin
        cmd.op    = osu_pkg::OP_HFETCH;
        state_nxt = ST_HBYTE;
      end
      ST_HBYTE: begin
        cmd.op    = osu_pkg::OP_HBYTE;
        state_nxt = sts.blk_full ? ST_ROUND : ST_HFETCH;
      end
      ST_ROUND: begin
        cmd.op = osu_pkg::OP_ROUND;
        if (sts.round_last) begin
          state_nxt = ST_HADD;
        end
      end
      ST_HADD: begin
        cmd.op = osu_pkg::OP_HADD;
        if (sts.more_blks) begin
          state_nxt = ST_HFETCH;
        end else begin
          state_nxt = job_r ? ST_DFETCH : ST_SFETCH;
        end
      end
      ST_SFETCH: begin
        cmd.op    = osu_pkg::OP_SFETCH;
        state_nxt = ST_SXOR;
      end
      ST_SXOR: begin
        cmd.op = osu_pkg::OP_SXOR;
        if (sts.j_last) begin
          state_nxt = ST_HINIT;
          job_nxt   = 1'b1;
        end else begin
          state_nxt = ST_SFETCH;
        end
      end
      ST_DFETCH: begin
        cmd.op    = osu_pkg::OP_DFETCH;
        state_nxt = ST_DWRITE;
      end
      ST_DWRITE: begin
        cmd.op = osu_pkg::OP_DWRITE;
        if (sts.db_last) begin
          state_nxt = ST_FIN;
        end else if (sts.j_last) begin
          state_nxt = ST_HINIT;
        end else begin
          state_nxt = ST_DFETCH;
        end
      end
      ST_FIN: begin
        cmd.op    = osu_pkg::OP_FIN;
        state_nxt = ST_OFETCH;
      end
      ST_OFETCH: begin
        cmd.op    = osu_pkg::OP_OFETCH;
        state_nxt = ST_OLOAD;
      end
      ST_OLOAD: begin
        cmd.op    = osu_pkg::OP_OLOAD;
        state_nxt = ST_OHOLD;
      end
      ST_OHOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = sts.out_last ? ST_LOAD : ST_OFETCH;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end
endmodule

// ----- rtl/core/osu_datapath.sv -----
// datapath: byte stores, sha-1 round unit, mask and check logic
module osu_datapath #(
  parameter int MAX_MODULUS_BYTES = 256,
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  osu_pkg::osu_cmd_t cmd,
  output osu_pkg::osu_sts_t sts,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_wdata,
  output logic [7:0]        msg_byte,
  output logic              decode_error,
  output logic              last_byte
);
  localparam int CW  = $clog2(MAX_MODULUS_BYTES + 1);
  localparam int AW  = $clog2(MAX_MODULUS_BYTES);
  localparam int PW  = CW + 1;
  localparam int MW  = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CTW = $clog2(MAX_MODULUS_BYTES / 20 + 1);

  logic [8:0]    mod_r;
  logic [6:0]    msgc_r;
  logic [CW-1:0] cnt_r;

  logic          err0_r, err_r, found_r;
  logic [CW-1:0] dblen_r, k_r, pos_r, start_r;
  logic [MW-1:0] mlen_r, oc_r;
  logic [4:0]    j_r;
  logic [CTW-1:0] ctr_r;
  logic [PW-1:0] p_r;
  logic [6:0]    t_r;
  logic [31:0]   h_r [5];
  logic [31:0]   v_r [5];
  logic [511:0]  msg_r;
  logic [7:0]    seed_r [20];
  logic [7:0]    msg_byte_r;
  logic          err_out_r, last_r;

  logic [9:0]    mod_x;
  logic [CW-1:0] len_use;
  logic [MW-1:0] mlen_use;
  logic [AW-1:0] idx;
  logic [CW-1:0] cnt_inc;
  logic          fire;

  logic [CW-1:0]   src_len, total;
  logic [PW-1:0]   tot_pad;
  logic [PW-7:0]   lastblk;
  logic [31:0]     bits32;
  logic [7:0]      hb;
  logic [7:0]      dig_byte;
  logic [31:0]     hw;
  logic [7:0]      enc_q, db_q, db_b;
  logic [AW-1:0]   enc_raddr;
  logic [PW-1:0]   out_pos;
  logic [CW-1:0]   start_c;

  logic [31:0] wx, w_new, f, kc, tmp;

  // lengths in use, clamped to their legal ranges
  always_comb begin
    mod_x = 10'(mod_r);
    if (mod_x < 10'(osu_pkg::ENC_MIN_BYTES)) begin
      len_use = CW'(osu_pkg::ENC_MIN_BYTES);
    end else if (mod_x > 10'(MAX_MODULUS_BYTES)) begin
      len_use = CW'(MAX_MODULUS_BYTES);
    end else begin
      len_use = CW'(mod_x);
    end
    if (msgc_r == 7'd0) begin
      mlen_use = MW'(1);
    end else if (msgc_r > 7'(MAX_MESSAGE_BYTES)) begin
      mlen_use = MW'(MAX_MESSAGE_BYTES);
    end else begin
      mlen_use = MW'(msgc_r);
    end
  end

  assign fire    = (cmd.op == osu_pkg::OP_LOAD) && in_valid;
  assign idx     = (cnt_r >= CW'(MAX_MODULUS_BYTES)) ? '0 : cnt_r[AW-1:0];
  assign cnt_inc = CW'(idx) + CW'(1);

  // message bytes of one sha-1 job: source, 32-bit counter, pad, bit length
  assign src_len = cmd.seed_src ? CW'(osu_pkg::SEED_BYTES) : dblen_r;
  assign total   = src_len + CW'(4);
  assign tot_pad = PW'(total) + PW'(8);
  assign lastblk = tot_pad[PW-1:6];
  assign bits32  = 32'(total) << 3;

  always_comb begin
    hb = 8'h00;
    if (p_r < PW'(src_len)) begin
      hb = cmd.seed_src ? seed_r[p_r[4:0]] : enc_q;
    end else if (p_r < PW'(total)) begin
      hb = (p_r == PW'(total) - PW'(1)) ? 8'(ctr_r) : 8'h00;
    end else if (p_r == PW'(total)) begin
      hb = 8'h80;
    end else if (p_r[PW-1:6] == lastblk && p_r[5:0] >= 6'd60) begin
      case (p_r[1:0])
        2'd0:    hb = bits32[31:24];
        2'd1:    hb = bits32[23:16];
        2'd2:    hb = bits32[15:8];
        default: hb = bits32[7:0];
      endcase
    end
  end

  // digest byte j of the chaining words
  always_comb begin
    hw = h_r[j_r[4:2]];
    case (j_r[1:0])
      2'd0:    dig_byte = hw[31:24];
      2'd1:    dig_byte = hw[23:16];
      2'd2:    dig_byte = hw[15:8];
      default: dig_byte = hw[7:0];
    endcase
  end

  assign db_b = dig_byte ^ enc_q;

  always_comb begin
    case (cmd.op)
      osu_pkg::OP_HFETCH: enc_raddr = AW'(PW'(p_r) + PW'(osu_pkg::HDR_BYTES));
      osu_pkg::OP_SFETCH: enc_raddr = AW'(j_r + 5'd1);
      default:            enc_raddr = AW'(k_r + CW'(osu_pkg::HDR_BYTES));
    endcase
  end

  assign out_pos = PW'(start_r) + PW'(oc_r);
  assign start_c = found_r ? pos_r + CW'(1) : dblen_r + CW'(1);

  // sha-1 round: schedule window shifts one word per round
  always_comb begin
    wx    = msg_r[95:64] ^ msg_r[255:224] ^ msg_r[447:416] ^ msg_r[511:480];
    w_new = {wx[30:0], wx[31]};
    if (t_r < 7'd20) begin
      f  = (v_r[1] & v_r[2]) | (~v_r[1] & v_r[3]);
      kc = osu_pkg::K0;
    end else if (t_r < 7'd40) begin
      f  = v_r[1] ^ v_r[2] ^ v_r[3];
      kc = osu_pkg::K1;
    end else if (t_r < 7'd60) begin
      f  = (v_r[1] & v_r[2]) | (v_r[1] & v_r[3]) | (v_r[2] & v_r[3]);
      kc = osu_pkg::K2;
    end else begin
      f  = v_r[1] ^ v_r[2] ^ v_r[3];
      kc = osu_pkg::K3;
    end
    tmp = {v_r[0][26:0], v_r[0][31:27]} + f + v_r[4] + kc + msg_r[511:480];
  end

  always_comb begin
    sts.run_start  = fire && (cnt_inc >= len_use);
    sts.blk_full   = (p_r[5:0] == 6'd63);
    sts.round_last = (t_r == 7'd79);
    sts.more_blks  = (p_r[PW-1:6] <= lastblk);
    sts.j_last     = (j_r == 5'(osu_pkg::SEED_BYTES - 1));
    sts.db_last    = (k_r == dblen_r - CW'(1));
    sts.out_last   = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= osu_pkg::MODULUS_RESET;
      msgc_r <= osu_pkg::MESSAGE_RESET;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          osu_pkg::CFG_MODULUS: mod_r  <= cfg_wdata;
          osu_pkg::CFG_MESSAGE: msgc_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (sts.run_start) begin
        cnt_r <= '0;
      end else if (fire) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && idx == '0) begin
      err0_r <= (in_byte != 8'h00);
    end
    if (sts.run_start) begin
      err_r   <= (idx == '0) ? (in_byte != 8'h00) : err0_r;
      dblen_r <= len_use - CW'(osu_pkg::HDR_BYTES);
      mlen_r  <= mlen_use;
      k_r     <= '0;
      ctr_r   <= '0;
      found_r <= 1'b0;
    end
    case (cmd.op)
      osu_pkg::OP_HINIT: begin
        h_r[0] <= osu_pkg::IV0; h_r[1] <= osu_pkg::IV1; h_r[2] <= osu_pkg::IV2;
        h_r[3] <= osu_pkg::IV3; h_r[4] <= osu_pkg::IV4;
        v_r[0] <= osu_pkg::IV0; v_r[1] <= osu_pkg::IV1; v_r[2] <= osu_pkg::IV2;
        v_r[3] <= osu_pkg::IV3; v_r[4] <= osu_pkg::IV4;
        p_r    <= '0;
        j_r    <= '0;
      end
      osu_pkg::OP_HBYTE: begin
        msg_r <= {msg_r[503:0], hb};
        p_r   <= p_r + PW'(1);
        t_r   <= '0;
      end
      osu_pkg::OP_ROUND: begin
        v_r[0] <= tmp;
        v_r[1] <= v_r[0];
        v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
        v_r[3] <= v_r[2];
        v_r[4] <= v_r[3];
        msg_r  <= {msg_r[479:0], w_new};
        t_r    <= t_r + 7'd1;
      end
      osu_pkg::OP_HADD: begin
        for (int i = 0; i < 5; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
          v_r[i] <= h_r[i] + v_r[i];
        end
      end
      osu_pkg::OP_SXOR: begin
        seed_r[j_r] <= db_b;
        j_r         <= j_r + 5'd1;
      end
      osu_pkg::OP_DWRITE: begin
        // label hash, then the zero run that must end in 0x01
        if (k_r < CW'(osu_pkg::SEED_BYTES)) begin
          if (db_b != osu_pkg::lhash_byte(k_r[4:0])) begin
            err_r <= 1'b1;
          end
        end else if (!found_r && db_b != 8'h00) begin
          found_r <= 1'b1;
          pos_r   <= k_r;
          if (db_b != 8'h01) begin
            err_r <= 1'b1;
          end
        end
        k_r <= k_r + CW'(1);
        j_r <= j_r + 5'd1;
        if (sts.j_last) begin
          ctr_r <= ctr_r + CTW'(1);
        end
      end
      osu_pkg::OP_FIN: begin
        start_r <= start_c;
        err_r   <= err_r | !found_r |
                   ((PW'(start_c) + PW'(mlen_r)) != PW'(dblen_r));
        oc_r    <= '0;
      end
      osu_pkg::OP_OLOAD: begin
        msg_byte_r <= (out_pos < PW'(dblen_r)) ? db_q : 8'h00;
        err_out_r  <= err_r;
        last_r     <= (oc_r == mlen_r - MW'(1));
        oc_r       <= oc_r + MW'(1);
      end
      default: ;
    endcase
  end

  osu_ram #(.WIDTH(8), .DEPTH(MAX_MODULUS_BYTES)) u_enc_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (idx),
    .wdata (in_byte),
    .raddr (enc_raddr),
    .rdata (enc_q)
  );

  osu_ram #(.WIDTH(8), .DEPTH(MAX_MODULUS_BYTES)) u_db_ram (
    .clk   (clk),
    .we    (cmd.op == osu_pkg::OP_DWRITE),
    .waddr (k_r[AW-1:0]),
    .wdata (db_b),
    .raddr (out_pos[AW-1:0]),
    .rdata (db_q)
  );

  assign msg_byte     = msg_byte_r;
  assign decode_error = err_out_r;
  assign last_byte    = last_r;
endmodule

// ----- rtl/core/oaep_sha1_unpad_unit.sv -----
// OAEP (SHA-1, MGF1, empty label) decoder for RSA-decrypted blocks.
// in_if takes the encoded message one byte per word, most significant
// first, one word a cycle while the unit is loading. When the byte count
// reaches modulus_bytes (clamped to 42..MAX_MODULUS_BYTES) input stops and
// the unit unmasks the seed and data block, checks the leading zero, the
// label hash, the zero run ending in 0x01 and the message length.
// The hashing runs on the single SHA-1 round unit (one round a cycle); each
// message byte is first fetched from the byte store, then shifted in.
// out_if then gives message_bytes words, each fetched once the receiver
// has taken the one before; decode_error is final on every word, and
// last_byte marks the end.
// A stalled receiver holds the word in the output register; nothing is lost.
// Reset clears the controller, the byte count and the registers (128, 64).
// cfg_we/cfg_index/cfg_wdata write a register; the user must do so only
// while idle, as the block itself does not enforce it.
module oaep_sha1_unpad_unit #(
  parameter int MAX_MODULUS_BYTES = 256,
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  osu_in_if.sink     in_if,
  osu_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata
);
  osu_pkg::osu_cmd_t cmd;
  osu_pkg::osu_sts_t sts;

  osu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid)
  );

  osu_datapath #(
    .MAX_MODULUS_BYTES (MAX_MODULUS_BYTES),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_valid     (in_if.valid),
    .in_byte      (in_if.enc_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .msg_byte     (out_if.msg_byte),
    .decode_error (out_if.decode_error),
    .last_byte    (out_if.last_byte)
  );
endmodule

// ----- rtl/core/osu_checker.sv -----
// port checker for the oaep sha-1 unpad unit, bound to the top level
`include "oaep_sha1_unpad_unit_assert.svh"
module osu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] msg_byte,
  input logic       decode_error,
  input logic       last_byte
);
  // stalled word holds
  `OSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(msg_byte) && $stable(decode_error) && $stable(last_byte), "stalled word changed")
  // no loading while results are pending
  `OSU_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input open during output")
  // run ends after the last word
  `OSU_ASSERT_NEXT(a_last_ends, out_valid && out_ready && last_byte, !out_valid, "word after last")
  // a byte just taken never yields a word in the next cycle
  `OSU_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind oaep_sha1_unpad_unit osu_checker u_osu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .msg_byte     (out_if.msg_byte),
  .decode_error (out_if.decode_error),
  .last_byte    (out_if.last_byte)
);
